### rtl/rgbd_pkg.sv
// ----------------------------------------------------------------------------
// rgbd_pkg
// Shared types, constants and the per-channel dither function of the
// RGB888 to RGB565/RGB555 converter.
// ----------------------------------------------------------------------------
package rgbd_pkg;

   localparam int REG_DIM_W   = 13;
   localparam int NUM_DIV     = 7;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [5:0] MAX_CH5 = 6'd31;
   localparam logic [5:0] MAX_CH6 = 6'd63;

   typedef enum logic [1:0] {
      DITHER_NONE    = 2'd0,
      DITHER_RANDOM  = 2'd1,
      DITHER_ORDERED = 2'd2
   } dither_mode_type;

   typedef enum logic [1:0] {
      CSR_GREEN  = 2'd0,
      CSR_DITHER = 2'd1,
      CSR_WIDTH  = 2'd2,
      CSR_HEIGHT = 2'd3
   } csr_index_type;

   // Entry k holds (column + row) mod (k + 2).
   typedef logic [NUM_DIV-1:0][2:0] residue_type;

   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [2:0]  rnd;
      residue_type pos_res;
      logic        last;
   } pixel_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [5:0] dither_ch(input logic [5:0]  value,
                                            input logic [2:0]  rem,
                                            input logic [5:0]  maxv,
                                            input logic [2:0]  rnd,
                                            input residue_type res,
                                            input logic [1:0]  mode);
      logic       bump;
      logic [2:0] idx;
      idx  = rem - 3'd1;
      bump = 1'b0;
      case (mode)
         DITHER_RANDOM: begin
            bump = rnd < rem;
         end
         DITHER_ORDERED: begin
            bump = (rem != 3'd0) && (res[idx] != 3'd0);
         end
         default: begin
            bump = 1'b0;
         end
      endcase
      return (bump && (value < maxv)) ? value + 6'd1 : value;
   endfunction

endpackage

### rtl/rgb888_to_rgb16_dither_core.sv
// ----------------------------------------------------------------------------
// rgb888_to_rgb16_dither_core
// Converts a raster stream of 24-bit RGB pixels to packed RGB565 or RGB555.
// ----------------------------------------------------------------------------
// The core takes one pixel per clock and gives one 16-bit pixel per clock for
// as long as results are popped. An accepted pixel passes through the
// two-entry queue behind the position tracker and then the output register
// before it can be popped. The output mode, dither mode and image size
// registers may be changed only while no pixel is in flight.
module rgb888_to_rgb16_dither_core import rgbd_pkg::*; #(
   parameter int MAX_DIM = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_red_in,
   input  logic [7:0]  req_green_in,
   input  logic [7:0]  req_blue_in,
   input  logic [2:0]  req_random_value,
   output logic        empty,
   input  logic        pop,
   output logic [15:0] rsp_pixel_out,
   output logic        rsp_last_pixel,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic                 green_ff;
   logic [1:0]           dither_ff;
   logic [REG_DIM_W-1:0] width_ff;
   logic [REG_DIM_W-1:0] height_ff;
   logic                 csr_write;
   csr_index_type        csr_index;
   queue_status_type     queue_status;
   pixel_item_type       push_item;
   pixel_item_type       pop_item;
   logic                 queue_push;
   logic                 queue_pop;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = csr_index_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         green_ff  <= 1'b1;
         dither_ff <= DITHER_NONE;
         width_ff  <= REG_DIM_W'(640);
         height_ff <= REG_DIM_W'(480);
      end else if (csr_write) begin
         case (csr_index)
            CSR_GREEN:  green_ff  <= pwdata[0];
            CSR_DITHER: dither_ff <= pwdata[1:0];
            CSR_WIDTH:  width_ff  <= pwdata[REG_DIM_W-1:0];
            CSR_HEIGHT: height_ff <= pwdata[REG_DIM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_GREEN:  prdata = {31'd0, green_ff};
         CSR_DITHER: prdata = {30'd0, dither_ff};
         CSR_WIDTH:  prdata = {{(32 - REG_DIM_W){1'b0}}, width_ff};
         CSR_HEIGHT: prdata = {{(32 - REG_DIM_W){1'b0}}, height_ff};
         default:    prdata = '0;
      endcase
   end

   rgbd_front #(
      .MAX_DIM (MAX_DIM)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .req_red_in       (req_red_in),
      .req_green_in     (req_green_in),
      .req_blue_in      (req_blue_in),
      .req_random_value (req_random_value),
      .image_width      (width_ff),
      .image_height     (height_ff),
      .queue_status     (queue_status),
      .queue_push       (queue_push),
      .queue_item       (push_item)
   );

   rgbd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (queue_push),
      .wr_item (push_item),
      .rd_en   (queue_pop),
      .rd_item (pop_item),
      .status  (queue_status)
   );

   rgbd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .green_six_bits (green_ff),
      .dither_select  (dither_ff),
      .queue_item     (pop_item),
      .queue_status   (queue_status),
      .queue_pop      (queue_pop),
      .pop            (pop),
      .empty          (empty),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_last_pixel (rsp_last_pixel)
   );

   assign full = queue_status.full;

endmodule

### rtl/rgbd_front.sv
// ----------------------------------------------------------------------------
// rgbd_front
// Accepts source pixels, tracks the raster position and the residues of
// column plus row for every ordered dither divisor, and flags the last pixel.
// ----------------------------------------------------------------------------
module rgbd_front import rgbd_pkg::*; #(
   parameter int MAX_DIM = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [7:0]           req_red_in,
   input  logic [7:0]           req_green_in,
   input  logic [7:0]           req_blue_in,
   input  logic [2:0]           req_random_value,
   input  logic [REG_DIM_W-1:0] image_width,
   input  logic [REG_DIM_W-1:0] image_height,
   input  queue_status_type     queue_status,
   output logic                 queue_push,
   output pixel_item_type       queue_item
);

   localparam int CNT_W = $clog2(MAX_DIM);
   localparam int DIM_W = $clog2(MAX_DIM) + 1;
   localparam int CMP_W = (DIM_W > REG_DIM_W) ? DIM_W : REG_DIM_W;

   logic [CNT_W-1:0] col_ff, col_in;
   logic [CNT_W-1:0] row_ff, row_in;
   residue_type      col_res_ff, col_res_in;
   residue_type      row_res_ff, row_res_in;
   residue_type      pos_res;
   logic [CMP_W-1:0] width_cl, height_cl;
   logic [CMP_W-1:0] col_plus, row_plus;
   logic             accept;
   logic             col_wrap;
   logic             row_wrap;
   logic [3:0]       res_sum [NUM_DIV];

   function automatic logic [CMP_W-1:0] clamp_dim(input logic [REG_DIM_W-1:0] v);
      logic [CMP_W-1:0] wide;
      wide = CMP_W'(v);
      if (wide == '0) begin
         return CMP_W'(1);
      end
      if (wide > CMP_W'(MAX_DIM)) begin
         return CMP_W'(MAX_DIM);
      end
      return wide;
   endfunction

   assign width_cl  = clamp_dim(image_width);
   assign height_cl = clamp_dim(image_height);
   assign col_plus  = CMP_W'(col_ff) + CMP_W'(1);
   assign row_plus  = CMP_W'(row_ff) + CMP_W'(1);
   assign col_wrap  = col_plus >= width_cl;
   assign row_wrap  = row_plus >= height_cl;
   assign accept    = push && !queue_status.full;

   always_comb begin
      col_in     = col_ff;
      row_in     = row_ff;
      col_res_in = col_res_ff;
      row_res_in = row_res_ff;
      if (accept) begin
         if (col_wrap) begin
            col_in     = '0;
            col_res_in = '0;
            if (row_wrap) begin
               row_in     = '0;
               row_res_in = '0;
            end else begin
               row_in = row_plus[CNT_W-1:0];
               for (int i = 0; i < NUM_DIV; i++) begin
                  row_res_in[i] = (row_res_ff[i] == 3'(i + 1)) ? 3'd0 : row_res_ff[i] + 3'd1;
               end
            end
         end else begin
            col_in = col_plus[CNT_W-1:0];
            for (int i = 0; i < NUM_DIV; i++) begin
               col_res_in[i] = (col_res_ff[i] == 3'(i + 1)) ? 3'd0 : col_res_ff[i] + 3'd1;
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_DIV; i++) begin
         res_sum[i] = {1'b0, col_res_ff[i]} + {1'b0, row_res_ff[i]};
         pos_res[i] = (res_sum[i] >= 4'(i + 2)) ? 3'(res_sum[i] - 4'(i + 2))
                                                 : res_sum[i][2:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         col_res_ff <= '0;
         row_res_ff <= '0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         col_res_ff <= col_res_in;
         row_res_ff <= row_res_in;
      end
   end

   assign queue_push         = accept;
   assign queue_item.red     = req_red_in;
   assign queue_item.green   = req_green_in;
   assign queue_item.blue    = req_blue_in;
   assign queue_item.rnd     = req_random_value;
   assign queue_item.pos_res = pos_res;
   assign queue_item.last    = col_wrap && row_wrap;

endmodule

### rtl/rgbd_queue.sv
// ----------------------------------------------------------------------------
// rgbd_queue
// Two-entry queue between the front and the back of the converter.
// ----------------------------------------------------------------------------
module rgbd_queue import rgbd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  pixel_item_type   wr_item,
   input  logic             rd_en,
   output pixel_item_type   rd_item,
   output queue_status_type status
);

   pixel_item_type    mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_en ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = rd_en ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (!wr_en && rd_en) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_item;
      end
   end

   assign rd_item      = mem_ff[rd_ptr_ff];
   assign status.full  = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign status.empty = count_ff == '0;

endmodule

### rtl/rgbd_back.sv
// ----------------------------------------------------------------------------
// rgbd_back
// Truncates and dithers the three channels of a queued pixel, packs the
// 16-bit result and holds it in the output register until it is taken.
// ----------------------------------------------------------------------------
module rgbd_back import rgbd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             green_six_bits,
   input  logic [1:0]       dither_select,
   input  pixel_item_type   queue_item,
   input  queue_status_type queue_status,
   output logic             queue_pop,
   input  logic             pop,
   output logic             empty,
   output logic [15:0]      rsp_pixel_out,
   output logic             rsp_last_pixel
);

   logic        out_valid_ff, out_valid_in;
   logic [15:0] pixel_ff, pixel_in;
   logic        last_ff;
   logic        load;
   logic [5:0]  red_d, blue_d, green_d;

   assign red_d  = dither_ch({1'b0, queue_item.red[7:3]}, queue_item.red[2:0], MAX_CH5,
                             queue_item.rnd, queue_item.pos_res, dither_select);
   assign blue_d = dither_ch({1'b0, queue_item.blue[7:3]}, queue_item.blue[2:0], MAX_CH5,
                             queue_item.rnd, queue_item.pos_res, dither_select);

   always_comb begin
      if (green_six_bits) begin
         green_d  = dither_ch(queue_item.green[7:2], {1'b0, queue_item.green[1:0]}, MAX_CH6,
                              {1'b0, queue_item.rnd[2:1]}, queue_item.pos_res,
                              dither_select);
         pixel_in = {red_d[4:0], green_d, blue_d[4:0]};
      end else begin
         green_d  = dither_ch({1'b0, queue_item.green[7:3]}, queue_item.green[2:0], MAX_CH5,
                              queue_item.rnd, queue_item.pos_res, dither_select);
         pixel_in = {1'b0, red_d[4:0], green_d[4:0], blue_d[4:0]};
      end
   end

   assign load = !queue_status.empty && (!out_valid_ff || pop);

   always_comb begin
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pixel_ff <= pixel_in;
         last_ff  <= queue_item.last;
      end
   end

   assign queue_pop      = load;
   assign empty          = !out_valid_ff;
   assign rsp_pixel_out  = pixel_ff;
   assign rsp_last_pixel = last_ff;

endmodule

### rtl/rgbd_checker.sv
// ----------------------------------------------------------------------------
// rgbd_checker
// Port-level checks of the converter's request and result queues.
// ----------------------------------------------------------------------------
module rgbd_checker (
   input logic        clock,
   input logic        reset,
   input logic        push,
   input logic        full,
   input logic        empty,
   input logic        pop,
   input logic [15:0] rsp_pixel_out,
   input logic        rsp_last_pixel
);

   a_reset_empty : assert property (@(posedge clock) reset |=> empty)
      else $error("Result queue is not empty after reset.");

   a_full_has_result : assert property (@(posedge clock) disable iff (reset)
      full |-> !empty)
      else $error("Request queue is full while no result is offered.");

   a_request_reaches_output : assert property (@(posedge clock) disable iff (reset)
      (push && !full && empty) |=> ##1 !empty)
      else $error("Accepted request did not produce a result in time.");

   a_result_holds : assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_pixel_out) && $stable(rsp_last_pixel)))
      else $error("Waiting result changed before it was popped.");

endmodule

bind rgb888_to_rgb16_dither_core rgbd_checker u_checker (.*);
